// ===== design/dtw_pkg.sv =====
// Shared types and constants for the leading-edge discriminator with dead time.
// Used by dtw_core and by the top level discriminator_dead_time_min_width.
// Has no dependencies of its own.
package dtw_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int FIELD_BITS    = 16;
    localparam int TIME_BITS_DEF = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_BITS      = 16;

    localparam logic [FIELD_BITS-1:0] FIELD_MAX = {FIELD_BITS{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEAD_TIME = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_WIDTH = 2'd2;

    // Register values after reset.
    localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RST = 16'd0;
    localparam logic [FIELD_BITS-1:0]  DEAD_TIME_RST = 16'd5;
    localparam logic [FIELD_BITS-1:0]  MIN_WIDTH_RST = 16'd10;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          trace_start;
    } t_in_item;

    typedef struct packed {
        logic                  disc_out;
        logic                  hit;
        logic [FIELD_BITS-1:0] interval;
        logic [FIELD_BITS-1:0] hit_total;
    } t_out_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] threshold;
        logic [FIELD_BITS-1:0]         dead_time;
        logic [FIELD_BITS-1:0]         min_width;
    } t_cfg;

endpackage

// ===== design/dtw_core.sv =====
// Discriminator state and the per-sample decision logic.
// Depends on dtw_pkg for the item, result and configuration types.
module dtw_core #(
    parameter int TIME_BITS = dtw_pkg::TIME_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  dtw_pkg::t_in_item i_data,
    input  dtw_pkg::t_cfg     i_cfg,
    output dtw_pkg::t_out_item o_res
);

    localparam int CMP_BITS = (TIME_BITS > dtw_pkg::FIELD_BITS) ? TIME_BITS
                                                                 : dtw_pkg::FIELD_BITS;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    logic                           r_is_high, r_rise_seen, r_fall_seen;
    logic [TIME_BITS-1:0]           r_since_rise, r_since_fall, r_since_hit;
    logic [dtw_pkg::FIELD_BITS-1:0] r_pulse_count;

    logic                           n_is_high, n_rise_seen, n_fall_seen;
    logic [TIME_BITS-1:0]           n_since_rise, n_since_fall, n_since_hit;
    logic [dtw_pkg::FIELD_BITS-1:0] n_pulse_count;

    logic                           base_high, base_rise, base_fall;
    logic [TIME_BITS-1:0]           base_since_rise, base_since_fall, base_since_hit;
    logic [dtw_pkg::FIELD_BITS-1:0] base_count;
    logic                           above, fire_ok, fall_ok;
    logic [CMP_BITS-1:0]            hit_wide;
    logic [dtw_pkg::FIELD_BITS-1:0] interval_sat;

    always_comb begin
        // A trace start clears everything before this sample is judged;
        // otherwise the time counters advance by one sample, saturating.
        if (i_data.trace_start) begin
            base_high       = 1'b0;
            base_rise       = 1'b0;
            base_fall       = 1'b0;
            base_since_rise = '0;
            base_since_fall = '0;
            base_since_hit  = '0;
            base_count      = '0;
        end else begin
            base_high       = r_is_high;
            base_rise       = r_rise_seen;
            base_fall       = r_fall_seen;
            base_since_rise = (r_since_rise == TIME_MAX) ? r_since_rise : r_since_rise + 1'b1;
            base_since_fall = (r_since_fall == TIME_MAX) ? r_since_fall : r_since_fall + 1'b1;
            base_since_hit  = (r_since_hit == TIME_MAX) ? r_since_hit : r_since_hit + 1'b1;
            base_count      = r_pulse_count;
        end

        above   = ($signed(i_data.sample) >= $signed(i_cfg.threshold));
        fire_ok = !base_fall ||
                  (CMP_BITS'(base_since_fall) >= CMP_BITS'(i_cfg.dead_time));
        fall_ok = !base_rise ||
                  (CMP_BITS'(base_since_rise) >= CMP_BITS'(i_cfg.min_width));

        hit_wide     = CMP_BITS'(base_since_hit);
        interval_sat = (hit_wide > CMP_BITS'(dtw_pkg::FIELD_MAX)) ? dtw_pkg::FIELD_MAX
                                                                  : hit_wide[dtw_pkg::FIELD_BITS-1:0];

        n_is_high     = base_high;
        n_rise_seen   = base_rise;
        n_fall_seen   = base_fall;
        n_since_rise  = base_since_rise;
        n_since_fall  = base_since_fall;
        n_since_hit   = base_since_hit;
        n_pulse_count = base_count;

        o_res.disc_out = 1'b0;
        o_res.hit      = 1'b0;
        o_res.interval = '0;

        if (above) begin
            if (fire_ok) begin
                if (!base_high) begin
                    o_res.hit      = 1'b1;
                    o_res.interval = interval_sat;
                    n_since_hit    = '0;
                    n_rise_seen    = 1'b1;
                    n_since_rise   = '0;
                    if (base_count != dtw_pkg::FIELD_MAX) begin
                        n_pulse_count = base_count + 1'b1;
                    end
                end
                n_is_high      = 1'b1;
                o_res.disc_out = 1'b1;
            end
        end else begin
            if (fall_ok) begin
                if (base_high) begin
                    n_fall_seen  = 1'b1;
                    n_since_fall = '0;
                end
                n_is_high = 1'b0;
            end else begin
                // Output is held high until the minimum width has passed.
                o_res.disc_out = 1'b1;
            end
        end

        o_res.hit_total = n_pulse_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_high     <= 1'b0;
            r_rise_seen   <= 1'b0;
            r_fall_seen   <= 1'b0;
            r_since_rise  <= '0;
            r_since_fall  <= '0;
            r_since_hit   <= '0;
            r_pulse_count <= '0;
        end else if (i_step) begin
            r_is_high     <= n_is_high;
            r_rise_seen   <= n_rise_seen;
            r_fall_seen   <= n_fall_seen;
            r_since_rise  <= n_since_rise;
            r_since_fall  <= n_since_fall;
            r_since_hit   <= n_since_hit;
            r_pulse_count <= n_pulse_count;
        end
    end

    // A high level always belongs to a rising edge seen in this trace.
    a_high_has_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_is_high |-> r_rise_seen)
        else $error("discriminator high without a recorded rising edge");

    // A hit restarts the interval counter and leaves a nonzero pulse count.
    a_hit_updates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.hit) |=> (r_since_hit == '0) && (r_pulse_count != '0))
        else $error("hit did not restart interval or count pulse");

    // Within a trace the pulse count never goes down.
    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_data.trace_start) |=> (r_pulse_count >= $past(r_pulse_count)))
        else $error("pulse count decreased inside a trace");

endmodule

// ===== design/discriminator_dead_time_min_width.sv =====
// Top level of the leading-edge discriminator with dead time and minimum width.
// Depends on dtw_pkg and instantiates dtw_core.
//
// This block takes one waveform sample per transaction and returns exactly one
// result transaction per sample: the discriminator level, a hit flag on each
// new pulse, the samples since the previous hit (or trace start) and the
// running hit count. It sustains one transaction per clock cycle while the
// result side is not stalling: a sample is captured in an input register,
// judged by the decision logic in dtw_core, and written to the result
// register, where its result is presented until it is taken.
// Throughput is set by the state update in dtw_core, which carries the
// counters from one sample to the next. The input side keeps accepting
// while a finished result waits to be taken; it stalls only during reset or
// when both the input and result registers are full and the result side is
// stalling. Configuration registers (threshold, dead time, minimum width)
// are written through a plain write port and should only be changed while
// no transaction is in flight.
module discriminator_dead_time_min_width #(
    parameter int TIME_BITS = dtw_pkg::TIME_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Sample channel.
    input  logic                             i_in_valid,
    input  dtw_pkg::t_in_item                i_in_data,
    output logic                             o_in_stall,
    // Result channel.
    output logic                             o_out_valid,
    output dtw_pkg::t_out_item               o_out_data,
    input  logic                             i_out_stall,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [dtw_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [dtw_pkg::CFG_BITS-1:0]     i_cfg_data
);

    logic               r_in_valid;
    dtw_pkg::t_in_item  r_in_data;
    logic               r_out_valid;
    dtw_pkg::t_out_item r_out_data;
    dtw_pkg::t_cfg      r_cfg;

    dtw_pkg::t_out_item core_res;
    logic               advance;
    logic               in_take;

    // The held sample moves to the result register whenever that register is
    // empty or being drained in this same cycle.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !i_rst_n || (r_in_valid && !advance);
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    dtw_core #(
        .TIME_BITS(TIME_BITS)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (advance),
        .i_data (r_in_data),
        .i_cfg  (r_cfg),
        .o_res  (core_res)
    );

    // Handshake state for the two pipeline registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; valid flags qualify them.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= core_res;
        end
    end

    // Configuration registers. Writes to unused indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= dtw_pkg::THRESHOLD_RST;
            r_cfg.dead_time <= dtw_pkg::DEAD_TIME_RST;
            r_cfg.min_width <= dtw_pkg::MIN_WIDTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dtw_pkg::CFG_THRESHOLD: begin
                    r_cfg.threshold <= i_cfg_data[dtw_pkg::SAMPLE_BITS-1:0];
                end
                dtw_pkg::CFG_DEAD_TIME: begin
                    r_cfg.dead_time <= i_cfg_data[dtw_pkg::FIELD_BITS-1:0];
                end
                dtw_pkg::CFG_MIN_WIDTH: begin
                    r_cfg.min_width <= i_cfg_data[dtw_pkg::FIELD_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== verif/tb_discriminator_dead_time_min_width.sv =====
// Self-checking testbench for discriminator_dead_time_min_width.
// Needs dtw_pkg and the block itself; carries its own predictor of the discriminator.
`timescale 1ns / 100ps

module tb_discriminator_dead_time_min_width;

    // Cycles with no transaction on either channel before the run is declared hung.
    // The slowest correct run waits out a long sender gap, a long result stall and
    // a configuration drain one after another, which stays well below this.
    localparam int IDLE_LIMIT   = 4000;
    // The block passes each taken sample through its input and result registers,
    // so these spare cycles let it settle before a register write or the end.
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int N_PHASES      = 10;
    localparam int PHASE_ITEMS   = 110;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} t_row_kind;

    // One line of the directed stimulus. A row either writes a register or sends
    // a sample; a sample row may carry its result typed in by hand.
    typedef struct {
        t_row_kind                        kind;
        logic [dtw_pkg::CFG_IDX_BITS-1:0] idx;
        logic [dtw_pkg::CFG_BITS-1:0]     value;
        dtw_pkg::t_in_item                item;
        bit                               typed;
        dtw_pkg::t_out_item               want;
    } t_dir_row;

    // Clock, reset and every block input start at a known value.
    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_in_valid  = 1'b0;
    dtw_pkg::t_in_item                i_in_data   = '0;
    logic                             o_in_stall;
    logic                             o_out_valid;
    dtw_pkg::t_out_item               o_out_data;
    logic                             i_out_stall = 1'b0;
    logic                             i_cfg_we    = 1'b0;
    logic [dtw_pkg::CFG_IDX_BITS-1:0] i_cfg_idx   = '0;
    logic [dtw_pkg::CFG_BITS-1:0]     i_cfg_data  = '0;

    // Shadow of the configuration registers, as the block holds them.
    logic signed [dtw_pkg::SAMPLE_BITS-1:0] thr_reg  = dtw_pkg::THRESHOLD_RST;
    logic [dtw_pkg::FIELD_BITS-1:0]         dead_reg = dtw_pkg::DEAD_TIME_RST;
    logic [dtw_pkg::FIELD_BITS-1:0]         minw_reg = dtw_pkg::MIN_WIDTH_RST;

    // Predictor copy of the discriminator state. It starts cleared, as reset leaves the block.
    bit                             lvl_high  = 1'b0;
    bit                             had_rise  = 1'b0;
    bit                             had_fall  = 1'b0;
    logic [dtw_pkg::FIELD_BITS-1:0] cnt_rise  = '0;
    logic [dtw_pkg::FIELD_BITS-1:0] cnt_fall  = '0;
    logic [dtw_pkg::FIELD_BITS-1:0] cnt_hit   = '0;
    logic [dtw_pkg::FIELD_BITS-1:0] pulses    = '0;

    // Results predicted for accepted samples, oldest first.
    dtw_pkg::t_out_item pending_results[$];
    t_dir_row           dir_rows[$];

    int idle_cycles = 0;
    int n_errors    = 0;
    int n_results   = 0;
    int n_hits      = 0;
    int n_directed  = 0;
    int n_random    = 0;
    int n_settings  = 0;

    always #1 i_clk = ~i_clk;

    discriminator_dead_time_min_width dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Saturating sample counter.
    function automatic logic [dtw_pkg::FIELD_BITS-1:0] bump(
        input logic [dtw_pkg::FIELD_BITS-1:0] c);
        return (c == dtw_pkg::FIELD_MAX) ? c : c + 1'b1;
    endfunction

    // Judges one sample against the shadow registers and the predictor state and
    // returns the result the block must give for it. A trace start clears the
    // state before the sample is judged; otherwise every time counter advances.
    function automatic dtw_pkg::t_out_item discriminate(input dtw_pkg::t_in_item it);
        dtw_pkg::t_out_item r;
        r = '0;
        if (it.trace_start) begin
            lvl_high = 1'b0;
            had_rise = 1'b0;
            had_fall = 1'b0;
            cnt_rise = '0;
            cnt_fall = '0;
            cnt_hit  = '0;
            pulses   = '0;
        end else begin
            cnt_rise = bump(cnt_rise);
            cnt_fall = bump(cnt_fall);
            cnt_hit  = bump(cnt_hit);
        end

        if ($signed(it.sample) >= $signed(thr_reg)) begin
            // Above threshold: fire unless the dead time after the last fall
            // is still running.
            if (!had_fall || cnt_fall >= dead_reg) begin
                if (!lvl_high) begin
                    r.hit      = 1'b1;
                    r.interval = cnt_hit;
                    cnt_hit    = '0;
                    pulses     = bump(pulses);
                    had_rise   = 1'b1;
                    cnt_rise   = '0;
                end
                lvl_high   = 1'b1;
                r.disc_out = 1'b1;
            end
        end else begin
            // Below threshold: fall unless the minimum width still holds the
            // output high.
            if (!had_rise || cnt_rise >= minw_reg) begin
                if (lvl_high) begin
                    had_fall = 1'b1;
                    cnt_fall = '0;
                end
                lvl_high = 1'b0;
            end else begin
                r.disc_out = 1'b1;
            end
        end
        r.hit_total = pulses;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // A sample placed above or below the current threshold, mostly close to it,
    // with some raw noise that ignores the threshold altogether.
    function automatic logic [dtw_pkg::SAMPLE_BITS-1:0] shape_sample(input bit above);
        int t;
        int v;
        t = $signed(thr_reg);
        if ($urandom_range(0, 11) == 0 || (!above && t == -32768)) begin
            v = $urandom_range(0, 65535);
            return v[dtw_pkg::SAMPLE_BITS-1:0];
        end
        v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40000) : $urandom_range(0, 40);
        v = above ? t + v : t - 1 - v;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[dtw_pkg::SAMPLE_BITS-1:0];
    endfunction

    function automatic logic [dtw_pkg::CFG_BITS-1:0] rand_threshold();
        int v;
        if ($urandom_range(0, 3) == 0) begin
            v = $urandom_range(0, 65535);
        end else begin
            v = $urandom_range(0, 4000) - 2000;
        end
        return v[dtw_pkg::CFG_BITS-1:0];
    endfunction

    function automatic logic [dtw_pkg::CFG_BITS-1:0] rand_time();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return dtw_pkg::FIELD_MAX;
        if (roll == 1) return dtw_pkg::CFG_BITS'($urandom_range(0, 65535));
        return dtw_pkg::CFG_BITS'($urandom_range(0, 12));
    endfunction

    function automatic void row_cfg(input logic [dtw_pkg::CFG_IDX_BITS-1:0] idx,
                                    input logic [dtw_pkg::CFG_BITS-1:0] value);
        t_dir_row row;
        row = '{kind: ROW_CFG, idx: idx, value: value, item: '0, typed: 1'b0, want: '0};
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void row_sample(input logic [dtw_pkg::SAMPLE_BITS-1:0] s,
                                       input bit ts);
        t_dir_row row;
        row = '{kind: ROW_SAMPLE, idx: '0, value: '0, item: '0, typed: 1'b0, want: '0};
        row.item.sample      = s;
        row.item.trace_start = ts;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // Sample row whose result is known without the predictor.
    function automatic void row_known(input logic [dtw_pkg::SAMPLE_BITS-1:0] s,
                                      input bit ts,
                                      input bit disc, input bit hit,
                                      input logic [dtw_pkg::FIELD_BITS-1:0] interval,
                                      input logic [dtw_pkg::FIELD_BITS-1:0] total);
        row_sample(s, ts);
        dir_rows[$].typed          = 1'b1;
        dir_rows[$].want.disc_out  = disc;
        dir_rows[$].want.hit       = hit;
        dir_rows[$].want.interval  = interval;
        dir_rows[$].want.hit_total = total;
    endfunction

    // Sends one sample transaction. Called and returning at a falling edge. The
    // expected result is queued at the rising edge that accepts the sample, so
    // the predictor sees samples in exactly the order the block takes them.
    task automatic push_sample(input dtw_pkg::t_in_item it, input bit typed,
                               input dtw_pkg::t_out_item want);
        int gap;
        dtw_pkg::t_out_item predicted;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = discriminate(it);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        @(negedge i_clk);
    endtask

    // Holds the sender off until every expected result has come back and the
    // block has had time to settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One register write; the shadow copy follows it. Only called while idle.
    task automatic write_reg(input logic [dtw_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [dtw_pkg::CFG_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            dtw_pkg::CFG_THRESHOLD: thr_reg  = value;
            dtw_pkg::CFG_DEAD_TIME: dead_reg = value;
            dtw_pkg::CFG_MIN_WIDTH: minw_reg = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [dtw_pkg::CFG_BITS-1:0] thr,
                              input logic [dtw_pkg::CFG_BITS-1:0] dead,
                              input logic [dtw_pkg::CFG_BITS-1:0] minw);
        wait_idle();
        write_reg(dtw_pkg::CFG_THRESHOLD, thr);
        write_reg(dtw_pkg::CFG_DEAD_TIME, dead);
        write_reg(dtw_pkg::CFG_MIN_WIDTH, minw);
        n_settings++;
    endtask

    // Sends a random sample with the given threshold side and trace-start flag.
    task automatic send_one(input bit above, input bit ts, inout int count);
        dtw_pkg::t_in_item it;
        it.sample      = shape_sample(above);
        it.trace_start = ts;
        push_sample(it, 1'b0, '0);
        count++;
    endtask

    // Random traces under the current register setting. Most traces begin with a
    // trace start and alternate runs below and above the threshold, so pulses,
    // dead-time blocks and width holds all occur; stray trace starts and raw
    // noise samples break the pattern now and then.
    task automatic run_phase(input int n_items, input bit drain_midway);
        int made;
        int left_in_trace;
        int run_left;
        bit above;
        bit ts;
        made = 0;
        while (made < n_items) begin
            left_in_trace = $urandom_range(8, 60);
            ts            = ($urandom_range(0, 9) != 0);
            above         = 1'b0;
            run_left      = $urandom_range(0, 10);
            while (left_in_trace > 0 && made < n_items) begin
                if (run_left == 0) begin
                    above    = !above;
                    run_left = above ? $urandom_range(1, 10) : $urandom_range(0, 10);
                end
                if (run_left > 0) begin
                    send_one(above, ts || ($urandom_range(0, 39) == 0), made);
                    ts = 1'b0;
                    run_left--;
                    left_in_trace--;
                    // Let the pipeline empty completely once in the middle of a
                    // phase, with no register write following.
                    if (drain_midway && made == n_items / 2) wait_idle();
                end
            end
        end
        n_random += made;
    endtask

    // Directed rows. Register values after reset are threshold 0, dead time 5 and
    // minimum width 10. Rows with a typed result are the ones that follow directly
    // from reset, a trace start or an extreme threshold.
    function automatic void build_directed();
        // No trace start after reset: the first sample is one sample into the trace.
        row_known(16'h8000, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0);
        row_known(16'h7FFF, 1'b0, 1'b1, 1'b1, 16'd2, 16'd1);
        // Below threshold inside the minimum width: held high.
        row_sample(16'hFFFF, 1'b0);
        // Zero minimum width: the next low sample drops the output.
        row_cfg(dtw_pkg::CFG_MIN_WIDTH, 16'd0);
        row_sample(16'hFFFF, 1'b0);
        // Exactly at threshold but inside the dead time: blocked.
        row_sample(16'h0000, 1'b0);
        // Zero dead time: the same sample now fires.
        row_cfg(dtw_pkg::CFG_DEAD_TIME, 16'd0);
        row_sample(16'h0000, 1'b0);
        // A trace start clears everything before the sample is judged.
        row_known(16'h0001, 1'b1, 1'b1, 1'b1, 16'd0, 16'd1);
        // Lowest threshold: even the most negative sample is at threshold.
        row_cfg(dtw_pkg::CFG_THRESHOLD, 16'h8000);
        row_known(16'h8000, 1'b0, 1'b1, 1'b0, 16'd0, 16'd1);
        // Highest threshold: one below it falls, the top value fires again.
        row_cfg(dtw_pkg::CFG_THRESHOLD, 16'h7FFF);
        row_sample(16'h7FFE, 1'b0);
        row_sample(16'h7FFF, 1'b0);
        // Largest windows.
        row_cfg(dtw_pkg::CFG_DEAD_TIME, 16'hFFFF);
        row_cfg(dtw_pkg::CFG_MIN_WIDTH, 16'hFFFF);
        row_sample(16'h8000, 1'b0);
        row_sample(16'h7FFF, 1'b0);
        row_known(16'h8000, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0);
        row_known(16'h7FFF, 1'b0, 1'b1, 1'b1, 16'd1, 16'd1);
        row_known(16'h7FFF, 1'b1, 1'b1, 1'b1, 16'd0, 16'd1);
        row_sample(16'h8000, 1'b0);
    endfunction

    // Counts a failure; only the first few are described.
    function automatic void report_failure(input string msg);
        n_errors++;
        if (n_errors <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            report_failure($sformatf("result %0d, %s: expected %0d, got %0d",
                                     n_results, field, want, got));
        end
    endfunction

    // Result side: every accepted result transaction is matched against the
    // oldest prediction, field by field.
    always @(posedge i_clk) begin : result_check
        dtw_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_failure($sformatf("result %0d arrived with no sample pending: %p",
                                         n_results, o_out_data));
            end else begin
                want = pending_results.pop_front();
                check_field("disc_out", want.disc_out, o_out_data.disc_out);
                check_field("hit", want.hit, o_out_data.hit);
                check_field("interval", want.interval, o_out_data.interval);
                check_field("hit_total", want.hit_total, o_out_data.hit_total);
            end
            if (o_out_data.hit === 1'b1) n_hits++;
            n_results++;
        end
    end

    // Cycles since the last transaction on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending_results.size());
        $display("Verification failed");
        $finish;
    end

    // Result side back-pressure: stall stretches of random length separated by
    // free stretches, some of them long so that the block also runs unthrottled.
    initial begin : result_stalls
        int stall_len;
        int free_len;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall_len = pick_gap();
            free_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150)
                                                     : $urandom_range(1, 6);
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat (free_len) @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int p;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows first, straight out of reset.
        build_directed();
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                wait_idle();
                write_reg(dir_rows[k].idx, dir_rows[k].value);
            end else begin
                push_sample(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
                n_directed++;
            end
        end

        // Random phases, each under its own register setting. The first three
        // pin the extremes: zero windows, the highest threshold with the largest
        // windows, and the lowest threshold.
        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                0: set_config(rand_threshold(), '0, '0);
                1: set_config(16'h7FFF, dtw_pkg::FIELD_MAX, dtw_pkg::FIELD_MAX);
                2: set_config(16'h8000, rand_time(), rand_time());
                default: set_config(rand_threshold(), rand_time(), rand_time());
            endcase
            run_phase(PHASE_ITEMS, p == 4);
        end

        // Drain, then keep watching the result channel for any stray result.
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d samples: %0d directed, %0d random",
                 n_directed + n_random, n_directed, n_random);
        $display("Checked %0d results with %0d hits over %0d register settings",
                 n_results, n_hits, n_settings);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches in total", n_errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/dtw_pkg.sv
design/dtw_core.sv
design/discriminator_dead_time_min_width.sv
verif/tb_discriminator_dead_time_min_width.sv
